@@ rtl/max_flow_dfs_augment_defines.svh @@
// Assertion macros for the max flow search block.
// Used by the checker module; no other dependencies.
`ifndef MAX_FLOW_DFS_AUGMENT_DEFINES_SVH
`define MAX_FLOW_DFS_AUGMENT_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define MFA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define MFA_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/mfa_pkg.sv @@
// Shared types and constants for the max flow search block.
// No dependencies.
`timescale 1ns / 1ps
package mfa_pkg;
   localparam int MAX_NODES = 64;
   localparam int NODE_BITS = $clog2(MAX_NODES);
   localparam int CNT_BITS = NODE_BITS + 1;
   localparam int CAP_BITS = 33;
   localparam int IN_CAP_BITS = 32;
   localparam int FLOW_BITS = 38;
   localparam int RES_DEPTH = MAX_NODES * MAX_NODES;
   localparam int RES_ADDR_BITS = 2 * NODE_BITS;
   localparam int STK_BITS = NODE_BITS + CNT_BITS + CAP_BITS;
   localparam logic [CNT_BITS-1:0] NODE_COUNT_RESET = CNT_BITS'(MAX_NODES);
   localparam logic [CAP_BITS-1:0] CAP_MAX = '1;
   localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_RUN = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [NODE_BITS-1:0]   from_node;
      logic [NODE_BITS-1:0]   to_node;
      logic [IN_CAP_BITS-1:0] edge_capacity;
   } mfa_req_type;

   typedef struct packed {
      logic [FLOW_BITS-1:0] total_flow;
      logic                 bad_request;
   } mfa_rsp_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] node;
      logic [CNT_BITS-1:0]  next;
      logic [CAP_BITS-1:0]  bottleneck;
   } mfa_stk_type;
endpackage

@@ rtl/mfa_ram.sv @@
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/max_flow_dfs_augment.sv @@
// Max flow engine: Ford-Fulkerson with depth-first search over a residual matrix.
// Depends on mfa_pkg and mfa_ram.
// After reset the block clears its 4096-entry capacity store, one entry a cycle, with busy high
// throughout. A write beat leaves the block idle, so writes may follow back to back. A valid run
// beat holds busy for the whole search. Every search, the first and each one after an augment,
// opens by clearing the visited marks, one node in use a cycle, and marks the source visited.
// After that each neighbour tried is a read of the capacity store, then a test; each backtrack
// a scan and a stack read; and each path edge a read-modify-write of the forward and reverse
// entries on the single capacity store write port. A bad run gives its result on the next cycle.
// The result is shown for one cycle with rsp_strobe and cannot be held off.
`timescale 1ns / 1ps
module max_flow_dfs_augment (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mfa_pkg::mfa_req_type req_data,
   output logic                 rsp_strobe,
   output mfa_pkg::mfa_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [6:0]           csr_wdata
);
   import mfa_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_CLEAR  = 10'b0000000010,
      ST_SCAN   = 10'b0000000100,
      ST_TEST   = 10'b0000001000,
      ST_POP    = 10'b0000010000,
      ST_AUG_RD = 10'b0000100000,
      ST_AUG_FW = 10'b0001000000,
      ST_AUG_RV = 10'b0010000000,
      ST_AUG_LD = 10'b0100000000,
      ST_VCLR   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [RES_ADDR_BITS-1:0] clr_ff, clr_in;
   logic [CNT_BITS-1:0] ncount_ff;
   logic rsp_valid_ff, rsp_valid_in;
   mfa_rsp_type rsp_ff, rsp_in;
   logic [NODE_BITS-1:0] vclr_ff, vclr_in;
   logic [NODE_BITS-1:0] src_ff, src_in, snk_ff, snk_in;
   logic [NODE_BITS-1:0] u_ff, u_in, d_ff, d_in, k_ff, k_in, a_ff, a_in, h_ff, h_in;
   logic [CNT_BITS-1:0] next_ff, next_in;
   logic [CAP_BITS-1:0] bot_ff, bot_in, b_ff, b_in;
   logic [FLOW_BITS-1:0] flow_ff, flow_in;

   logic res_we;
   logic [RES_ADDR_BITS-1:0] res_waddr, res_raddr;
   logic [CAP_BITS-1:0] res_wdata, res_rdata;
   logic stk_we;
   logic [NODE_BITS-1:0] stk_waddr, stk_raddr;
   mfa_stk_type stk_wdata, stk_rdata;
   logic vis_we;
   logic [NODE_BITS-1:0] vis_waddr, vis_raddr;
   logic vis_wdata, vis_rdata;

   logic [CNT_BITS-1:0] n_eff;
   logic [CAP_BITS-1:0] cmin;
   logic [CAP_BITS:0] rsum;
   logic [FLOW_BITS:0] fsum;
   logic [NODE_BITS-1:0] vidx;

   assign n_eff = (ncount_ff > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES) : ncount_ff;
   assign vidx = next_ff[NODE_BITS-1:0];
   assign cmin = (bot_ff < res_rdata) ? bot_ff : res_rdata;
   assign rsum = {1'b0, res_rdata} + {1'b0, b_ff};
   assign fsum = {1'b0, flow_ff} + (FLOW_BITS+1)'(b_ff);

   mfa_ram #(.WIDTH(CAP_BITS), .DEPTH(RES_DEPTH)) u_res (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_waddr),
      .wr_data (res_wdata),
      .rd_addr (res_raddr),
      .rd_data (res_rdata)
   );

   mfa_ram #(.WIDTH(STK_BITS), .DEPTH(MAX_NODES)) u_stk (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   mfa_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr (vis_raddr),
      .rd_data (vis_rdata)
   );

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      vclr_in = vclr_ff;
      src_in = src_ff;
      snk_in = snk_ff;
      u_in = u_ff;
      d_in = d_ff;
      k_in = k_ff;
      a_in = a_ff;
      h_in = h_ff;
      next_in = next_ff;
      bot_in = bot_ff;
      b_in = b_ff;
      flow_in = flow_ff;
      res_we = 1'b0;
      res_waddr = {a_ff, h_ff};
      res_wdata = '0;
      res_raddr = {u_ff, vidx};
      stk_we = 1'b0;
      stk_waddr = d_ff;
      stk_wdata = '{node: u_ff, next: next_ff + 1'b1, bottleneck: bot_ff};
      stk_raddr = d_ff - 1'b1;
      vis_we = 1'b0;
      vis_waddr = vclr_ff;
      vis_wdata = (vclr_ff == src_ff);
      vis_raddr = vidx;
      unique case (state_ff)
         ST_CLEAR: begin
            res_we = 1'b1;
            res_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == RES_ADDR_BITS'(RES_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_data.req_type == REQ_WRITE) begin
                  res_we = 1'b1;
                  res_waddr = {req_data.from_node, req_data.to_node};
                  res_wdata = CAP_BITS'(req_data.edge_capacity);
               end else if (req_data.from_node == req_data.to_node
                            || CNT_BITS'(req_data.from_node) >= n_eff
                            || CNT_BITS'(req_data.to_node) >= n_eff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{total_flow: '0, bad_request: 1'b1};
               end else begin
                  src_in = req_data.from_node;
                  snk_in = req_data.to_node;
                  flow_in = '0;
                  vclr_in = '0;
                  u_in = req_data.from_node;
                  next_in = '0;
                  bot_in = CAP_MAX;
                  d_in = '0;
                  state_in = ST_VCLR;
               end
            end
         end
         ST_VCLR: begin
            vis_we = 1'b1;
            vclr_in = vclr_ff + 1'b1;
            if (CNT_BITS'(vclr_ff) == n_eff - 1'b1) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (next_ff >= n_eff) begin
               if (d_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{total_flow: flow_ff, bad_request: 1'b0};
                  state_in = ST_IDLE;
               end else begin
                  d_in = d_ff - 1'b1;
                  state_in = ST_POP;
               end
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            next_in = next_ff + 1'b1;
            state_in = ST_SCAN;
            if (!vis_rdata && res_rdata != '0) begin
               if (vidx == snk_ff) begin
                  b_in = cmin;
                  a_in = u_ff;
                  h_in = snk_ff;
                  k_in = d_ff;
                  state_in = ST_AUG_RD;
               end else if (d_ff != NODE_BITS'(MAX_NODES - 1)) begin
                  stk_we = 1'b1;
                  d_in = d_ff + 1'b1;
                  vis_we = 1'b1;
                  vis_waddr = vidx;
                  vis_wdata = 1'b1;
                  u_in = vidx;
                  next_in = '0;
                  bot_in = cmin;
               end
            end
         end
         ST_POP: begin
            u_in = stk_rdata.node;
            next_in = stk_rdata.next;
            bot_in = stk_rdata.bottleneck;
            state_in = ST_SCAN;
         end
         ST_AUG_RD: begin
            res_raddr = {a_ff, h_ff};
            state_in = ST_AUG_FW;
         end
         ST_AUG_FW: begin
            res_we = 1'b1;
            res_wdata = res_rdata - b_ff;
            res_raddr = {h_ff, a_ff};
            state_in = ST_AUG_RV;
         end
         ST_AUG_RV: begin
            res_we = 1'b1;
            res_waddr = {h_ff, a_ff};
            res_wdata = rsum[CAP_BITS] ? CAP_MAX : rsum[CAP_BITS-1:0];
            if (k_ff == '0) begin
               flow_in = fsum[FLOW_BITS] ? FLOW_MAX : fsum[FLOW_BITS-1:0];
               vclr_in = '0;
               u_in = src_ff;
               next_in = '0;
               bot_in = CAP_MAX;
               d_in = '0;
               state_in = ST_VCLR;
            end else begin
               stk_raddr = k_ff - 1'b1;
               k_in = k_ff - 1'b1;
               h_in = a_ff;
               state_in = ST_AUG_LD;
            end
         end
         ST_AUG_LD: begin
            a_in = stk_rdata.node;
            res_raddr = {stk_rdata.node, h_ff};
            state_in = ST_AUG_FW;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ncount_ff <= NODE_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            ncount_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      vclr_ff <= vclr_in;
      src_ff <= src_in;
      snk_ff <= snk_in;
      u_ff <= u_in;
      d_ff <= d_in;
      k_ff <= k_in;
      a_ff <= a_in;
      h_ff <= h_in;
      next_ff <= next_in;
      bot_ff <= bot_in;
      b_ff <= b_in;
      flow_ff <= flow_in;
   end
endmodule

@@ rtl/mfa_checker.sv @@
// Port-level checks for the max flow search block, bound to the top level.
// Depends on mfa_pkg and max_flow_dfs_augment_defines.svh.
`timescale 1ns / 1ps
`include "max_flow_dfs_augment_defines.svh"
module mfa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input mfa_pkg::mfa_req_type req_data,
   input logic                 rsp_strobe,
   input mfa_pkg::mfa_rsp_type rsp_data
);
   import mfa_pkg::*;

   `MFA_ASSERT(a_write_silent, clock, reset, (start && !busy && req_data.req_type == REQ_WRITE) |=> !rsp_strobe, "result beat after write")
   `MFA_ASSERT(a_idle_on_beat, clock, reset, rsp_strobe |-> !busy, "result beat while busy")
   `MFA_ASSERT(a_run_starts, clock, reset, (start && !busy && req_data.req_type == REQ_RUN) |=> (busy || rsp_strobe), "run beat dropped")
   `MFA_NEVER(a_bad_zero, clock, reset, rsp_strobe && rsp_data.bad_request && rsp_data.total_flow != '0, "bad run with flow")
endmodule

bind max_flow_dfs_augment mfa_checker u_mfa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
